FILE: design/tep_pkg.sv
// Shared types, byte codes and a helper function for the terminal escape event parser.
package tep_pkg;

  localparam logic [7:0] BYTE_NUL      = 8'h00;
  localparam logic [7:0] BYTE_ESC      = 8'h1b;
  localparam logic [7:0] BYTE_LBRACKET = 8'h5b;
  localparam logic [7:0] BYTE_LESS     = 8'h3c;
  localparam logic [7:0] BYTE_KEY_END  = 8'h75;
  localparam logic [7:0] BYTE_PRESS    = 8'h4d;
  localparam logic [7:0] BYTE_RELEASE  = 8'h6d;
  localparam logic [7:0] BYTE_SEMI     = 8'h3b;
  localparam logic [7:0] BYTE_COLON    = 8'h3a;
  localparam logic [7:0] BYTE_ZERO     = 8'h30;
  localparam logic [7:0] BYTE_NINE     = 8'h39;

  localparam logic KIND_KEY   = 1'b0;
  localparam logic KIND_MOUSE = 1'b1;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_ESC   = 4'b0010,
    MODE_CSI   = 4'b0100,
    MODE_MOUSE = 4'b1000
  } mode_t;

  typedef enum logic [5:0] {
    KP_CODE     = 6'b000001,
    KP_MOD      = 6'b000010,
    KP_SEEK     = 6'b000100,
    KP_ACTION   = 6'b001000,
    KP_DONE_NOC = 6'b010000,
    KP_DONE_COL = 6'b100000
  } key_phase_t;

  typedef enum logic [3:0] {
    MP_BUTTON = 4'b0001,
    MP_X      = 4'b0010,
    MP_Y      = 4'b0100,
    MP_DONE   = 4'b1000
  } mouse_phase_t;

  // One parameter byte as both interpreters see it.
  typedef struct packed {
    logic       clear;
    logic       feed;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_semi;
    logic       is_colon;
  } param_feed_t;

  // Decimal accumulate that saturates at limit.
  function automatic logic [31:0] sat_dec(input logic [31:0] acc, input logic [3:0] digit,
                                          input logic [31:0] limit);
    logic [35:0] v;
    v = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1) + {32'd0, digit};
    return (v > {4'b0000, limit}) ? limit : v[31:0];
  endfunction

endpackage

FILE: design/tep_key_interp.sv
// Keyboard layout interpreter: codepoint ; modifier : event type.
module tep_key_interp
  import tep_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  param_feed_t feed,
  output logic [31:0] key_codepoint,
  output logic [7:0]  key_modifiers,
  output logic [7:0]  key_action
);

  key_phase_t  key_phase, key_phase_next;
  logic [31:0] codepoint_acc, codepoint_acc_next;
  logic [8:0]  modifier_acc, modifier_acc_next;
  logic [7:0]  action_acc, action_acc_next;
  logic [31:0] cp_sat, mod_sat, act_sat;

  assign cp_sat  = sat_dec(codepoint_acc, feed.digit, 32'hFFFF_FFFF);
  assign mod_sat = sat_dec({23'd0, modifier_acc}, feed.digit, 32'd256);
  assign act_sat = sat_dec({24'd0, action_acc}, feed.digit, 32'd255);

  always_comb begin
    key_phase_next     = key_phase;
    codepoint_acc_next = codepoint_acc;
    modifier_acc_next  = modifier_acc;
    action_acc_next    = action_acc;
    if (feed.clear) begin
      key_phase_next     = KP_CODE;
      codepoint_acc_next = '0;
      modifier_acc_next  = '0;
      action_acc_next    = '0;
    end else if (feed.feed) begin
      case (key_phase)
        KP_CODE: begin
          if (feed.is_digit) codepoint_acc_next = cp_sat;
          else key_phase_next = feed.is_semi ? KP_MOD : KP_DONE_NOC;
        end
        KP_MOD: begin
          if (feed.is_digit) modifier_acc_next = mod_sat[8:0];
          else key_phase_next = feed.is_colon ? KP_ACTION : KP_SEEK;
        end
        KP_SEEK: begin
          if (feed.is_colon) key_phase_next = KP_ACTION;
        end
        KP_ACTION: begin
          if (feed.is_digit) action_acc_next = act_sat[7:0];
          else key_phase_next = KP_DONE_COL;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_phase     <= KP_CODE;
      codepoint_acc <= '0;
      modifier_acc  <= '0;
      action_acc    <= '0;
    end else begin
      key_phase     <= key_phase_next;
      codepoint_acc <= codepoint_acc_next;
      modifier_acc  <= modifier_acc_next;
      action_acc    <= action_acc_next;
    end
  end

  logic       mod_seen, act_seen;
  logic [8:0] mod_less;

  assign mod_seen = (key_phase == KP_MOD) || (key_phase == KP_SEEK) ||
                    (key_phase == KP_ACTION) || (key_phase == KP_DONE_COL);
  assign act_seen = (key_phase == KP_ACTION) || (key_phase == KP_DONE_COL);
  assign mod_less = modifier_acc - 9'd1;

  assign key_codepoint = codepoint_acc;
  assign key_modifiers = (mod_seen && (modifier_acc != 9'd0)) ? mod_less[7:0] : 8'd0;
  assign key_action    = act_seen ? action_acc : 8'd1;

endmodule

FILE: design/tep_mouse_interp.sv
// SGR mouse layout interpreter: button ; column ; row.
module tep_mouse_interp
  import tep_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  param_feed_t feed,
  output logic [7:0]  mouse_button,
  output logic [15:0] mouse_x,
  output logic [15:0] mouse_y
);

  mouse_phase_t mouse_phase, mouse_phase_next;
  logic [7:0]   button_acc, button_acc_next;
  logic [15:0]  column_acc, column_acc_next;
  logic [15:0]  row_acc, row_acc_next;
  logic [31:0]  btn_sat, col_sat, row_sat;

  assign btn_sat = sat_dec({24'd0, button_acc}, feed.digit, 32'd255);
  assign col_sat = sat_dec({16'd0, column_acc}, feed.digit, 32'd65535);
  assign row_sat = sat_dec({16'd0, row_acc}, feed.digit, 32'd65535);

  always_comb begin
    mouse_phase_next = mouse_phase;
    button_acc_next  = button_acc;
    column_acc_next  = column_acc;
    row_acc_next     = row_acc;
    if (feed.clear) begin
      mouse_phase_next = MP_BUTTON;
      button_acc_next  = '0;
      column_acc_next  = '0;
      row_acc_next     = '0;
    end else if (feed.feed) begin
      case (mouse_phase)
        MP_BUTTON: begin
          if (feed.is_digit) button_acc_next = btn_sat[7:0];
          else mouse_phase_next = feed.is_semi ? MP_X : MP_DONE;
        end
        MP_X: begin
          if (feed.is_digit) column_acc_next = col_sat[15:0];
          else mouse_phase_next = feed.is_semi ? MP_Y : MP_DONE;
        end
        MP_Y: begin
          if (feed.is_digit) row_acc_next = row_sat[15:0];
          else mouse_phase_next = MP_DONE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mouse_phase <= MP_BUTTON;
      button_acc  <= '0;
      column_acc  <= '0;
      row_acc     <= '0;
    end else begin
      mouse_phase <= mouse_phase_next;
      button_acc  <= button_acc_next;
      column_acc  <= column_acc_next;
      row_acc     <= row_acc_next;
    end
  end

  assign mouse_button = button_acc;
  assign mouse_x      = column_acc;
  assign mouse_y      = row_acc;

endmodule

FILE: design/terminal_escape_event_parser_core.sv
// Top level of the terminal escape event parser: byte register, mode control, result register.
//
// The block takes one terminal byte per transfer on the input channel (in_valid, in_stall,
// in_byte) and gives keyboard or SGR mouse events on the output channel (out_valid,
// out_stall and the event fields). Most bytes give no event; a 'u' that closes a CSI
// sequence with a nonzero codepoint, or an 'M' or 'm' that closes a mouse sequence,
// gives exactly one.
// A byte accepted on the input channel is held in the byte register, then decoded and applied
// to the mode and interpreter state; any event it closes is loaded into the result register
// and offered from there. Throughput is one byte per cycle while the receiver does not stall;
// the per-byte work is one decimal multiply-accumulate per field and a mode update, all between
// the byte register and the result register.
// When the receiver stalls while an event waits, the held byte is not applied and the
// input stalls in turn; the waiting event and its fields hold steady until taken.
// Synchronous reset returns the parser to idle mode with empty registers on both sides.
// PARAM_BUFFER_BYTES less one is how many parameter bytes one sequence may carry; the
// next parameter byte makes the parser drop the sequence and return to idle.
module terminal_escape_event_parser_core
  import tep_pkg::*;
#(
  parameter int PARAM_BUFFER_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        event_kind,
  output logic [31:0] key_codepoint,
  output logic [7:0]  key_modifiers,
  output logic [7:0]  key_action,
  output logic [7:0]  mouse_button,
  output logic [15:0] mouse_x,
  output logic [15:0] mouse_y,
  output logic        mouse_release
);

  localparam int CountWidth = $clog2(PARAM_BUFFER_BYTES);
  localparam logic [CountWidth-1:0] CountLast = CountWidth'(PARAM_BUFFER_BYTES - 1);

  // Input byte register.
  logic       byte_valid;
  logic [7:0] byte_q;
  logic       fire;

  // The held byte is applied only when the result register can take whatever it gives.
  assign fire     = byte_valid && (!out_valid || !out_stall);
  assign in_stall = byte_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!in_stall) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_q <= in_byte;
    end
  end

  // Parser control state.
  mode_t                 mode, mode_next;
  logic [CountWidth-1:0] param_count, param_count_next;
  logic                  text_ended, text_ended_next;
  param_feed_t           feed;
  logic                  res_load;
  logic                  res_kind;

  logic [31:0] ki_codepoint;
  logic [7:0]  ki_modifiers, ki_action;
  logic [7:0]  mi_button;
  logic [15:0] mi_x, mi_y;

  logic is_digit;
  assign is_digit = (byte_q >= BYTE_ZERO) && (byte_q <= BYTE_NINE);

  always_comb begin
    logic [7:0] digit_full;
    logic       param_path;
    digit_full       = byte_q - BYTE_ZERO;
    param_path       = 1'b0;
    mode_next        = mode;
    param_count_next = param_count;
    text_ended_next  = text_ended;
    res_load         = 1'b0;
    res_kind         = KIND_KEY;
    feed.clear       = 1'b0;
    feed.feed        = 1'b0;
    feed.is_digit    = is_digit;
    feed.digit       = is_digit ? digit_full[3:0] : 4'd0;
    feed.is_semi     = (byte_q == BYTE_SEMI);
    feed.is_colon    = (byte_q == BYTE_COLON);

    if (fire) begin
      case (mode)
        MODE_IDLE: begin
          if (byte_q == BYTE_ESC) begin
            mode_next        = MODE_ESC;
            param_count_next = '0;
          end
        end
        MODE_ESC: begin
          param_count_next = '0;
          if (byte_q == BYTE_LBRACKET) begin
            mode_next       = MODE_CSI;
            text_ended_next = 1'b0;
            feed.clear      = 1'b1;
          end else begin
            mode_next = MODE_IDLE;
          end
        end
        MODE_CSI: begin
          if (byte_q == BYTE_LESS) begin
            mode_next = MODE_MOUSE;
          end else if (byte_q == BYTE_KEY_END) begin
            mode_next = MODE_IDLE;
            // A keyboard sequence with a zero codepoint is dropped.
            res_load  = (ki_codepoint != 32'd0);
            res_kind  = KIND_KEY;
          end else begin
            param_path = 1'b1;
          end
        end
        MODE_MOUSE: begin
          if ((byte_q == BYTE_PRESS) || (byte_q == BYTE_RELEASE)) begin
            mode_next = MODE_IDLE;
            res_load  = 1'b1;
            res_kind  = KIND_MOUSE;
          end else begin
            param_path = 1'b1;
          end
        end
        default: begin
          mode_next = MODE_IDLE;
        end
      endcase

      // Parameter byte: count, interpret until text ends; at the limit, drop the sequence.
      if (param_path) begin
        if (param_count < CountLast) begin
          param_count_next = param_count + CountWidth'(1);
          text_ended_next  = text_ended || (byte_q == BYTE_NUL);
          feed.feed        = !text_ended_next;
        end else begin
          mode_next        = MODE_IDLE;
          param_count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      param_count <= '0;
      text_ended  <= 1'b0;
    end else begin
      mode        <= mode_next;
      param_count <= param_count_next;
      text_ended  <= text_ended_next;
    end
  end

  tep_key_interp u_key (
    .clk          (clk),
    .rst          (rst),
    .feed         (feed),
    .key_codepoint(ki_codepoint),
    .key_modifiers(ki_modifiers),
    .key_action   (ki_action)
  );

  tep_mouse_interp u_mouse (
    .clk         (clk),
    .rst         (rst),
    .feed        (feed),
    .mouse_button(mi_button),
    .mouse_x     (mi_x),
    .mouse_y     (mi_y)
  );

  // Result register. Fields of the other event kind are forced to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      event_kind <= res_kind;
      if (res_kind == KIND_MOUSE) begin
        key_codepoint <= '0;
        key_modifiers <= '0;
        key_action    <= '0;
        mouse_button  <= mi_button;
        mouse_x       <= mi_x;
        mouse_y       <= mi_y;
        mouse_release <= (byte_q == BYTE_RELEASE);
      end else begin
        key_codepoint <= ki_codepoint;
        key_modifiers <= ki_modifiers;
        key_action    <= ki_action;
        mouse_button  <= '0;
        mouse_x       <= '0;
        mouse_y       <= '0;
        mouse_release <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // Events only come out of the two parameter modes.
  a_result_mode: assert property (@(posedge clk) disable iff (rst)
    res_load |-> ((mode == MODE_CSI) || (mode == MODE_MOUSE)))
    else $error("event produced outside a parameter mode");

  // A waiting event is never overwritten by the next byte.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !res_load)
    else $error("result register overwritten while stalled");

  // The parameter count never passes the buffer limit.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    param_count <= CountLast)
    else $error("parameter count beyond buffer size");

  // A keyboard event always carries a nonzero codepoint.
  a_key_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_kind == KIND_KEY)) |-> (key_codepoint != 32'd0))
    else $error("keyboard event with zero codepoint");
`endif

endmodule
